FILE: rtl/itba_pkg.sv
`default_nettype none
package itba_pkg;

  localparam logic [15:0] QUARTER = 16'h4000;
  localparam logic [15:0] HALF    = 16'h8000;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  localparam logic [1:0] KIND_ASIN = 2'd0;
  localparam logic [1:0] KIND_ACOS = 2'd1;
  localparam logic [1:0] KIND_ATAN = 2'd2;

  // Per-item control that travels beside the arithmetic.
  typedef struct packed {
    logic [1:0]  kind;
    logic        vneg;
    logic        cneg;
    logic        sneg;
    logic        use_sin;
    logic        zero;
    logic [17:0] vmag;
  } itba_ctl_t;

  // Folding decisions for the table stage.
  typedef struct packed {
    logic acos_sel;
    logic neg;
    logic sat;
    logic post_neg;
    logic force_zero;
  } itba_fold_t;

  // Sine of a quarter-turn angle in Q30, Taylor series; elaboration only.
  function automatic logic [63:0] sine_q30(input logic [15:0] a);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x = (64'(a) * TWO_PI_Q30) >> 16;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) sum = sum - term;
      else sum = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [15:0] asin_entry(input int i, input int n);
    int k;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] mid;
    logic [63:0] target;
    k = (i >= n) ? n - 1 : i;
    target = 64'(k) << 30;
    lo = 16'd0;
    hi = QUARTER;
    while (lo < hi) begin
      mid = 16'((32'(lo) + 32'(hi) + 32'd1) >> 1);
      if (sine_q30(mid) * 64'(n) <= target) lo = mid;
      else hi = mid - 16'd1;
    end
    return lo;
  endfunction

  function automatic logic [15:0] acos_entry(input int i, input int n);
    int k;
    k = (i >= n) ? n - 1 : i;
    if (k == 0) return QUARTER;
    return QUARTER - 16'd1 - asin_entry(k, n);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/itba_front.sv
`default_nettype none
module itba_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [1:0]           kind,
  input  wire logic signed [17:0]   value,
  input  wire logic signed [31:0]   cos_part,
  input  wire logic signed [31:0]   sin_part,
  output logic                      out_valid,
  output itba_pkg::itba_ctl_t       out_ctl,
  output logic [63:0]               out_sumsq,
  output logic [31:0]               out_part
);

  logic                v1_r, v2_r, v3_r, v4_r, v5_r;
  itba_pkg::itba_ctl_t ctl1_r, ctl1_nxt, ctl2_r, ctl2_nxt, ctl3_r, ctl4_r, ctl5_r;
  logic [31:0]         cm1_r, sm1_r, cm2_r, sm2_r, cn3_r, sn3_r;
  logic [31:0]         cm1_nxt, sm1_nxt, big;
  logic [4:0]          sh2_r, sh2_nxt;
  logic [63:0]         cc4_r, ss4_r, sum5_r;
  logic [31:0]         part4_r, part5_r;

  always_comb begin
    ctl1_nxt = '0;
    ctl1_nxt.kind = kind;
    ctl1_nxt.vneg = value[17];
    ctl1_nxt.cneg = cos_part[31];
    ctl1_nxt.sneg = sin_part[31];
    ctl1_nxt.vmag = value[17] ? 18'(-value) : value;
    cm1_nxt = cos_part[31] ? 32'(-cos_part) : cos_part;
    sm1_nxt = sin_part[31] ? 32'(-sin_part) : sin_part;
    ctl1_nxt.use_sin = sm1_nxt < cm1_nxt;
  end

  // Shift that brings the larger magnitude up to bit 30.
  always_comb begin
    big = (cm1_r > sm1_r) ? cm1_r : sm1_r;
    sh2_nxt = 5'd0;
    for (int b = 0; b <= 30; b++) begin
      if (big[b]) sh2_nxt = 5'(30 - b);
    end
    ctl2_nxt = ctl1_r;
    ctl2_nxt.zero = (big == 32'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1_r  <= ctl1_nxt;
      cm1_r   <= cm1_nxt;
      sm1_r   <= sm1_nxt;
      ctl2_r  <= ctl2_nxt;
      cm2_r   <= cm1_r;
      sm2_r   <= sm1_r;
      sh2_r   <= sh2_nxt;
      ctl3_r  <= ctl2_r;
      cn3_r   <= cm2_r << sh2_r;
      sn3_r   <= sm2_r << sh2_r;
      ctl4_r  <= ctl3_r;
      cc4_r   <= 64'(cn3_r) * 64'(cn3_r);
      ss4_r   <= 64'(sn3_r) * 64'(sn3_r);
      part4_r <= ctl3_r.use_sin ? sn3_r : cn3_r;
      ctl5_r  <= ctl4_r;
      sum5_r  <= cc4_r + ss4_r;
      part5_r <= part4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_ctl   = ctl5_r;
  assign out_sumsq = sum5_r;
  assign out_part  = part5_r;

endmodule
`default_nettype wire

FILE: rtl/itba_sqrt.sv
`default_nettype none
module itba_sqrt (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire itba_pkg::itba_ctl_t  in_ctl,
  input  wire logic [63:0]          in_sumsq,
  input  wire logic [31:0]          in_part,
  output logic                      out_valid,
  output itba_pkg::itba_ctl_t       out_ctl,
  output logic [31:0]               out_root,
  output logic [31:0]               out_part
);

  // Two result bits per stage, thirty-two bits in all.
  localparam int PerStage = 2;
  localparam int NumStages = 32 / PerStage;

  logic                v_r    [0:NumStages-1];
  itba_pkg::itba_ctl_t ctl_r  [0:NumStages-1];
  logic [31:0]         part_r [0:NumStages-1];
  logic [63:0]         rad_r  [0:NumStages-1];
  logic [35:0]         rem_r  [0:NumStages-1];
  logic [31:0]         root_r [0:NumStages-1];

  logic                v_in    [0:NumStages];
  itba_pkg::itba_ctl_t ctl_in  [0:NumStages];
  logic [31:0]         part_in [0:NumStages];
  logic [63:0]         rad_in  [0:NumStages];
  logic [35:0]         rem_in  [0:NumStages];
  logic [31:0]         root_in [0:NumStages];

  assign v_in[0]    = in_valid;
  assign ctl_in[0]  = in_ctl;
  assign part_in[0] = in_part;
  assign rad_in[0]  = in_sumsq;
  assign rem_in[0]  = '0;
  assign root_in[0] = '0;

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    logic [63:0] rad_nxt;
    logic [35:0] rem_nxt;
    logic [31:0] root_nxt;

    always_comb begin
      logic [35:0] trial;
      rad_nxt  = rad_in[k];
      rem_nxt  = rem_in[k];
      root_nxt = root_in[k];
      for (int j = 0; j < PerStage; j++) begin
        rem_nxt = {rem_nxt[33:0], rad_nxt[63:62]};
        trial = {2'b00, root_nxt, 2'b01};
        if (rem_nxt >= trial) begin
          rem_nxt  = rem_nxt - trial;
          root_nxt = {root_nxt[30:0], 1'b1};
        end else begin
          root_nxt = {root_nxt[30:0], 1'b0};
        end
        rad_nxt = {rad_nxt[61:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl_r[k]  <= ctl_in[k];
        part_r[k] <= part_in[k];
        rad_r[k]  <= rad_nxt;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
      end
    end

    assign v_in[k+1]    = v_r[k];
    assign ctl_in[k+1]  = ctl_r[k];
    assign part_in[k+1] = part_r[k];
    assign rad_in[k+1]  = rad_r[k];
    assign rem_in[k+1]  = rem_r[k];
    assign root_in[k+1] = root_r[k];
  end

  assign out_valid = v_in[NumStages];
  assign out_ctl   = ctl_in[NumStages];
  assign out_root  = root_in[NumStages];
  assign out_part  = part_in[NumStages];

endmodule
`default_nettype wire

FILE: rtl/itba_div.sv
`default_nettype none
module itba_div (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire itba_pkg::itba_ctl_t  in_ctl,
  input  wire logic [31:0]          in_root,
  input  wire logic [31:0]          in_part,
  output logic                      out_valid,
  output itba_pkg::itba_ctl_t       out_ctl,
  output logic [16:0]               out_ratio
);

  // The part never exceeds the root, so the 1.16 ratio fits in 17 bits.
  localparam int DivSteps = 17;
  localparam int PerStage = 2;
  localparam int NumStages = (DivSteps + PerStage - 1) / PerStage;

  logic                v_r    [0:NumStages-1];
  itba_pkg::itba_ctl_t ctl_r  [0:NumStages-1];
  logic [31:0]         den_r  [0:NumStages-1];
  logic [32:0]         rem_r  [0:NumStages-1];
  logic [16:0]         lo_r   [0:NumStages-1];
  logic [16:0]         quo_r  [0:NumStages-1];

  logic                v_in   [0:NumStages];
  itba_pkg::itba_ctl_t ctl_in [0:NumStages];
  logic [31:0]         den_in [0:NumStages];
  logic [32:0]         rem_in [0:NumStages];
  logic [16:0]         lo_in  [0:NumStages];
  logic [16:0]         quo_in [0:NumStages];

  assign v_in[0]   = in_valid;
  assign ctl_in[0] = in_ctl;
  assign den_in[0] = in_root;
  assign rem_in[0] = {2'b00, in_part[31:1]};
  assign lo_in[0]  = {in_part[0], 16'd0};
  assign quo_in[0] = '0;

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    logic [32:0] rem_nxt;
    logic [16:0] lo_nxt;
    logic [16:0] quo_nxt;

    always_comb begin
      rem_nxt = rem_in[k];
      lo_nxt  = lo_in[k];
      quo_nxt = quo_in[k];
      for (int j = 0; j < PerStage; j++) begin
        if (k * PerStage + j < DivSteps) begin
          rem_nxt = {rem_nxt[31:0], lo_nxt[16]};
          lo_nxt  = {lo_nxt[15:0], 1'b0};
          if (rem_nxt >= {1'b0, den_in[k]}) begin
            rem_nxt = rem_nxt - {1'b0, den_in[k]};
            quo_nxt = {quo_nxt[15:0], 1'b1};
          end else begin
            quo_nxt = {quo_nxt[15:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl_r[k] <= ctl_in[k];
        den_r[k] <= den_in[k];
        rem_r[k] <= rem_nxt;
        lo_r[k]  <= lo_nxt;
        quo_r[k] <= quo_nxt;
      end
    end

    assign v_in[k+1]   = v_r[k];
    assign ctl_in[k+1] = ctl_r[k];
    assign den_in[k+1] = den_r[k];
    assign rem_in[k+1] = rem_r[k];
    assign lo_in[k+1]  = lo_r[k];
    assign quo_in[k+1] = quo_r[k];
  end

  assign out_valid = v_in[NumStages];
  assign out_ctl   = ctl_in[NumStages];
  assign out_ratio = quo_in[NumStages];

endmodule
`default_nettype wire

FILE: rtl/itba_interp.sv
`default_nettype none
module itba_interp #(
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire itba_pkg::itba_ctl_t  in_ctl,
  input  wire logic [16:0]          in_ratio,
  output logic                      out_valid,
  output logic [15:0]               out_angle
);

  localparam int IdxW = $clog2(TABLE_ENTRIES);
  localparam int ProdW = 16 + IdxW;
  localparam logic [ProdW-1:0] EntriesW = ProdW'(TABLE_ENTRIES);

  logic [15:0] asin_tab [0:TABLE_ENTRIES];
  logic [15:0] acos_tab [0:TABLE_ENTRIES];

  for (genvar g = 0; g <= TABLE_ENTRIES; g++) begin : g_tab
    localparam logic [15:0] AsinVal = itba_pkg::asin_entry(g, TABLE_ENTRIES);
    localparam logic [15:0] AcosVal = itba_pkg::acos_entry(g, TABLE_ENTRIES);
    assign asin_tab[g] = AsinVal;
    assign acos_tab[g] = AcosVal;
  end

  logic                 v1_r, v2_r, v3_r, v4_r;
  itba_pkg::itba_fold_t fold1_r, fold1_nxt, fold2_r, fold3_r;
  logic [IdxW-1:0]      idx1_r;
  logic [15:0]          w1_r, w2_r;
  logic [15:0]          t0_2_r, t1_2_r, t0_3_r;
  logic signed [17:0]   step3_r;
  logic [15:0]          angle4_r, angle4_nxt;
  logic [17:0]          mag;
  logic [ProdW-1:0]     pos;
  logic                 is_atan;
  logic [IdxW:0]        idx_hi;
  logic signed [16:0]   diff;
  logic signed [33:0]   prod;
  logic [15:0]          base;

  always_comb begin
    is_atan = (in_ctl.kind == itba_pkg::KIND_ATAN);
    mag = is_atan ? {1'b0, in_ratio} : in_ctl.vmag;
    pos = ProdW'(mag[15:0]) * EntriesW;
    fold1_nxt.acos_sel = (in_ctl.kind == itba_pkg::KIND_ACOS) || (is_atan && !in_ctl.use_sin);
    fold1_nxt.neg = is_atan ? (in_ctl.use_sin ? in_ctl.sneg : in_ctl.cneg) : in_ctl.vneg;
    fold1_nxt.sat = mag[17] | mag[16];
    fold1_nxt.post_neg = is_atan && (in_ctl.use_sin ? in_ctl.cneg : in_ctl.sneg);
    fold1_nxt.force_zero = (in_ctl.kind != itba_pkg::KIND_ASIN)
                        && (in_ctl.kind != itba_pkg::KIND_ACOS)
                        && !(is_atan && !in_ctl.zero);
  end

  assign idx_hi = {1'b0, idx1_r} + (IdxW+1)'(1);

  // Differences are rounded toward minus infinity by the arithmetic shift.
  always_comb begin
    diff = signed'({1'b0, t1_2_r}) - signed'({1'b0, t0_2_r});
    prod = 34'(diff) * signed'({18'd0, w2_r});
  end

  always_comb begin
    base = t0_3_r + 16'(step3_r);
    if (fold3_r.acos_sel) begin
      if (fold3_r.sat) angle4_nxt = 16'd0;
      else if (fold3_r.neg) angle4_nxt = itba_pkg::HALF - base;
      else angle4_nxt = base;
      if (fold3_r.post_neg) angle4_nxt = 16'd0 - angle4_nxt;
    end else begin
      if (fold3_r.sat) angle4_nxt = itba_pkg::QUARTER;
      else if (fold3_r.neg) angle4_nxt = 16'd0 - base;
      else angle4_nxt = base;
      if (fold3_r.post_neg) angle4_nxt = itba_pkg::HALF - angle4_nxt;
    end
    if (fold3_r.force_zero) angle4_nxt = 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fold1_r  <= fold1_nxt;
      idx1_r   <= pos[ProdW-1:16];
      w1_r     <= pos[15:0];
      fold2_r  <= fold1_r;
      w2_r     <= w1_r;
      t0_2_r   <= fold1_r.acos_sel ? acos_tab[idx1_r] : asin_tab[idx1_r];
      t1_2_r   <= fold1_r.acos_sel ? acos_tab[idx_hi] : asin_tab[idx_hi];
      fold3_r  <= fold2_r;
      t0_3_r   <= t0_2_r;
      step3_r  <= prod[33:16];
      angle4_r <= angle4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_angle = angle4_r;

endmodule
`default_nettype wire

FILE: rtl/inverse_trig_binary_angle.sv
// Arcsine, arccosine and two-argument arctangent in binary angle units
// (65536 per turn). Each input item on the in_ channel carries a kind in
// in_tuser and its operands in in_tdata; each item yields exactly one result
// item on the out_ channel with the 16-bit angle in out_tdata.
// Arcsine and arccosine interpolate a table over the unsigned 2.16 magnitude.
// Arctangent normalizes the vector, takes a pipelined square root of the sum
// of squares, divides the smaller component by it and folds by quadrant.
// From acceptance to the result register: 5 front stages, 16 root stages (two
// root bits each), 9 divide stages (two quotient bits each, one in the last)
// and 4 table stages. One item is accepted every cycle unless stalled.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stall on out_tready holds every stage in place and
// drops in_tready in the same cycle; nothing is lost or repeated.
// Synchronous reset clears all valid bits; no item is in flight afterward.
`default_nettype none
module inverse_trig_binary_angle #(
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [87:0] in_tdata,  // value[17:0], cos_part[49:18], sin_part[81:50], zeros
  input  wire logic [1:0]  in_tuser,  // kind[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata  // angle_out[15:0]
);

  logic                en;
  logic                f_valid, s_valid, d_valid;
  itba_pkg::itba_ctl_t f_ctl, s_ctl, d_ctl;
  logic [63:0]         f_sumsq;
  logic [31:0]         f_part, s_part, s_root;
  logic [16:0]         d_ratio;

  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  itba_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .kind      (in_tuser),
    .value     (signed'(in_tdata[17:0])),
    .cos_part  (signed'(in_tdata[49:18])),
    .sin_part  (signed'(in_tdata[81:50])),
    .out_valid (f_valid),
    .out_ctl   (f_ctl),
    .out_sumsq (f_sumsq),
    .out_part  (f_part)
  );

  itba_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid),
    .in_ctl    (f_ctl),
    .in_sumsq  (f_sumsq),
    .in_part   (f_part),
    .out_valid (s_valid),
    .out_ctl   (s_ctl),
    .out_root  (s_root),
    .out_part  (s_part)
  );

  itba_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s_valid),
    .in_ctl    (s_ctl),
    .in_root   (s_root),
    .in_part   (s_part),
    .out_valid (d_valid),
    .out_ctl   (d_ctl),
    .out_ratio (d_ratio)
  );

  itba_interp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_valid),
    .in_ctl    (d_ctl),
    .in_ratio  (d_ratio),
    .out_valid (out_tvalid),
    .out_angle (out_tdata)
  );

endmodule
`default_nettype wire
